/* src/arm_pkg.sv */
package arm_pkg;

  localparam int unsigned THR_BITS     = 12;
  localparam int unsigned RANGE_BITS   = 4;
  localparam int unsigned SEL_BITS     = 8;
  localparam int unsigned VOLT_BITS    = 22;
  localparam int unsigned RES_BITS     = 34;
  localparam int unsigned TEMP_BITS    = 19;
  localparam int unsigned COEF_BITS    = 38;
  localparam int unsigned ROM_DEPTH    = 8;
  localparam int unsigned ROM_IDX_BITS = 3;
  localparam int unsigned CFG_IDX_BITS = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_UPPER = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_LOWER = 1'b1;

  localparam logic [THR_BITS-1:0]   UPPER_RESET = 12'd3950;
  localparam logic [THR_BITS-1:0]   LOWER_RESET = 12'd210;
  localparam logic [RANGE_BITS-1:0] RANGE_RESET = 4'd3;

  localparam logic [VOLT_BITS-1:0] VOLT_SCALE = 22'd3300000;

  // Temperature: t = 2^S * TEMP_BASE - raw * TEMP_SCALE, rounded quotient
  // = floor(floor(t / 2^(S+1)) / 1721). The offset makes the dividend positive
  // so the divide by 1721 is a reciprocal multiply.
  localparam int unsigned TEMP_BASE_BITS  = 28;
  localparam int unsigned TEMP_SCALE_BITS = 30;
  localparam int unsigned TEMP_V_BITS     = 29;
  localparam int unsigned RECIP_BITS      = 30;
  localparam int unsigned RECIP_SHIFT     = 40;
  localparam logic [TEMP_BASE_BITS-1:0]  TEMP_BASE   = 28'd150495121;
  localparam logic [TEMP_SCALE_BITS-1:0] TEMP_SCALE  = 30'd660000000;
  localparam logic [TEMP_V_BITS-1:0]     TEMP_OFFSET = 29'd255052200;
  localparam logic [RECIP_BITS-1:0]      TEMP_RECIP  = 30'd638879505;
  localparam logic [TEMP_BITS-1:0]       TEMP_BIAS   = 19'd148200;

  // Q16 reciprocal coefficients, one row per channel, one entry per range
  localparam logic [COEF_BITS-1:0] COEF_ROM [0:1][0:ROM_DEPTH-1] = '{
    '{38'd18993, 38'd189928, 38'd1899281, 38'd18924731, 38'd189247312,
      38'd1955555556, 38'd19555555556, 38'd176000000000},
    '{38'd14505, 38'd145055, 38'd1450549, 38'd14505495, 38'd145054945,
      38'd1466666667, 38'd14666666667, 38'd176000000000}
  };

  typedef struct packed {
    logic [RES_BITS-1:0]   resistance;
    logic [VOLT_BITS-1:0]  voltage;
    logic [SEL_BITS-1:0]   select;
    logic [RANGE_BITS-1:0] used_range;
  } chan_res_t;

endpackage

/* src/arm_channel.sv */
module arm_channel #(
  parameter int unsigned CHANNEL     = 0,
  parameter int unsigned RANGE_COUNT = 8,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          advance_i,
  input  logic [SAMPLE_BITS-1:0]        sample_i,
  input  logic [arm_pkg::THR_BITS-1:0]  upper_i,
  input  logic [arm_pkg::THR_BITS-1:0]  lower_i,
  output arm_pkg::chan_res_t            result_o
);
  import arm_pkg::*;

  localparam int unsigned CMP_W  = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;
  localparam int unsigned PROD_W = SAMPLE_BITS + COEF_BITS;

  logic [RANGE_BITS-1:0]         range_q, range_d;
  logic                          step_up, step_down;
  logic [RANGE_BITS:0]           range_sum;
  logic [ROM_IDX_BITS-1:0]       rom_idx;
  logic [COEF_BITS-1:0]          coef;
  logic [PROD_W-1:0]             res_prod, res_shift;
  logic [SAMPLE_BITS+VOLT_BITS-1:0] volt_prod;
  logic [SEL_BITS-1:0]           select;

  assign step_up   = CMP_W'(sample_i) > CMP_W'(upper_i);
  assign step_down = CMP_W'(sample_i) < CMP_W'(lower_i);

  // range_q never drops below one, so the sum cannot wrap
  always_comb begin
    range_sum = {1'b0, range_q} + (RANGE_BITS+1)'(step_up) - (RANGE_BITS+1)'(step_down);
    if (range_sum == '0) begin
      range_d = RANGE_BITS'(1);
    end else if (range_sum > (RANGE_BITS+1)'(RANGE_COUNT)) begin
      range_d = RANGE_BITS'(RANGE_COUNT);
    end else begin
      range_d = range_sum[RANGE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q <= RANGE_RESET;
    end else if (advance_i) begin
      range_q <= range_d;
    end
  end

  // ranges past the table reuse its top entry
  always_comb begin
    if (range_q > RANGE_BITS'(ROM_DEPTH)) begin
      rom_idx = ROM_IDX_BITS'(ROM_DEPTH - 1);
    end else begin
      rom_idx = ROM_IDX_BITS'(range_q - RANGE_BITS'(1));
    end
  end

  assign coef      = COEF_ROM[CHANNEL[0]][rom_idx];
  assign res_prod  = sample_i * coef;
  assign res_shift = res_prod >> (SAMPLE_BITS + 4);
  assign volt_prod = sample_i * VOLT_SCALE;

  always_comb begin
    for (int k = 0; k < SEL_BITS; k++) begin
      select[k] = (range_d == RANGE_BITS'(k + 1));
    end
  end

  always_comb begin
    result_o.used_range = range_q;
    result_o.select     = select;
    result_o.voltage    = volt_prod[SAMPLE_BITS+VOLT_BITS-1:SAMPLE_BITS];
    if (|res_shift[PROD_W-1:RES_BITS]) begin
      result_o.resistance = '1;
    end else begin
      result_o.resistance = res_shift[RES_BITS-1:0];
    end
  end

endmodule

/* src/autorange_resistance_meter.sv */
// Two-channel autoranging resistance meter with die-temperature readout. Each
// stream transaction carries one sample per measurement channel and one from
// the temperature sensor; each result gives, per channel, the range used for
// that sample, voltage in microvolts, resistance in tenths of ohms and the
// one-hot select of the next range, plus the temperature in hundredths of a
// degree. One item is taken every clock cycle unless back-pressure stalls the
// pipeline: an input register feeds one combinational pass (one multiplier
// per channel field and the saturating range step) into the result register,
// and the temperature scaling is split across the input register, its first
// product ahead of it and the reciprocal divide after it. Range state
// advances once per item in arrival order. Threshold writes take effect on
// the next item and need no clearing after reset.
module autorange_resistance_meter #(
  parameter int unsigned RANGE_COUNT = 8,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // sample_first, sample_second, sample_temperature, zero pad
  input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // used_range_first, select_first, voltage_first, resistance_first,
  // used_range_second, select_second, voltage_second, resistance_second,
  // temperature_centi, zero pad
  output logic [159:0]                      m_axis_tdata_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [arm_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [arm_pkg::THR_BITS-1:0]      cfg_data_i
);
  import arm_pkg::*;

  localparam int unsigned TW    = SAMPLE_BITS + 31;
  localparam int unsigned OUT_W = 2 * $bits(chan_res_t) + TEMP_BITS;
  localparam int unsigned TQ_W  = TEMP_V_BITS + RECIP_BITS;

  logic [THR_BITS-1:0] upper_q, lower_q;

  logic                   a_valid_q;
  logic [SAMPLE_BITS-1:0] a_first_q, a_second_q;
  logic [TEMP_V_BITS-1:0] a_temp_q;

  logic                   b_valid_q;
  chan_res_t              b_first_q, b_second_q;
  logic [TEMP_BITS-1:0]   b_temp_q;

  logic s_ready, b_ready, advance;
  chan_res_t res_first, res_second;

  logic [SAMPLE_BITS-1:0]                 in_temp;
  logic [TW-1:0]                          temp_base, temp_off;
  logic [SAMPLE_BITS+TEMP_SCALE_BITS-1:0] temp_prod;
  logic signed [TW-1:0]                   temp_num, temp_shift;
  logic [TQ_W-1:0]                        temp_quot_prod;
  logic [TEMP_BITS-1:0]                   temp_centi;

  assign b_ready         = !b_valid_q || m_axis_tready_i;
  assign s_ready         = !a_valid_q || b_ready;
  assign advance         = a_valid_q && b_ready;
  assign s_axis_tready_o = s_ready;
  assign m_axis_tvalid_o = b_valid_q;
  assign cfg_ready_o     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q <= UPPER_RESET;
      lower_q <= LOWER_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_UPPER: upper_q <= cfg_data_i;
        REG_LOWER: lower_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // first half of the temperature conversion, ahead of the input register
  assign in_temp    = s_axis_tdata_i[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
  assign temp_base  = TW'(TEMP_BASE) << SAMPLE_BITS;
  assign temp_prod  = in_temp * TEMP_SCALE;
  assign temp_num   = $signed(temp_base - TW'(temp_prod));
  assign temp_shift = temp_num >>> (SAMPLE_BITS + 1);
  assign temp_off   = $unsigned(temp_shift) + TW'(TEMP_OFFSET);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (s_ready) begin
      a_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_ready && s_axis_tvalid_i) begin
      a_first_q  <= s_axis_tdata_i[SAMPLE_BITS-1:0];
      a_second_q <= s_axis_tdata_i[2*SAMPLE_BITS-1:SAMPLE_BITS];
      a_temp_q   <= temp_off[TEMP_V_BITS-1:0];
    end
  end

  arm_channel #(
    .CHANNEL    (0),
    .RANGE_COUNT(RANGE_COUNT),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_first (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .advance_i(advance),
    .sample_i (a_first_q),
    .upper_i  (upper_q),
    .lower_i  (lower_q),
    .result_o (res_first)
  );

  arm_channel #(
    .CHANNEL    (1),
    .RANGE_COUNT(RANGE_COUNT),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_second (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .advance_i(advance),
    .sample_i (a_second_q),
    .upper_i  (upper_q),
    .lower_i  (lower_q),
    .result_o (res_second)
  );

  // divide by 1721 through the reciprocal, then drop the offset
  assign temp_quot_prod = a_temp_q * TEMP_RECIP;
  assign temp_centi = temp_quot_prod[RECIP_SHIFT+TEMP_BITS-1:RECIP_SHIFT] - TEMP_BIAS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      b_first_q  <= res_first;
      b_second_q <= res_second;
      b_temp_q   <= temp_centi;
    end
  end

  assign m_axis_tdata_o = {(160 - OUT_W)'(0), b_temp_q, b_second_q, b_first_q};

endmodule

/* sim/autorange_resistance_meter_test.sv */
module autorange_resistance_meter_test;
  import arm_pkg::*;

  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned IN_W       = ((3 * SAMPLE_W + 7) / 8) * 8;
  localparam int unsigned PIPE_DEPTH = 2;
  localparam int unsigned QUIET_MAX  = 2000;
  localparam longint unsigned RES_SAT = 64'd17179869183;

  typedef struct packed {
    logic [SAMPLE_W-1:0] temperature;
    logic [SAMPLE_W-1:0] second;
    logic [SAMPLE_W-1:0] first;
  } meter_sample_t;

  typedef struct packed {
    logic [TEMP_BITS-1:0] temperature;
    chan_res_t            second;
    chan_res_t            first;
  } meter_reading_t;

  class meter_scoreboard;
    logic [THR_BITS-1:0]   upper;
    logic [THR_BITS-1:0]   lower;
    logic [RANGE_BITS-1:0] range_first;
    logic [RANGE_BITS-1:0] range_second;
    longint unsigned       coef_tab [2][8];
    meter_reading_t        expected_readings [$];
    int                    errors;
    int                    samples_in;
    int                    readings_checked;
    logic [7:0]            ranges_first_seen;
    logic [7:0]            ranges_second_seen;

    function new();
      coef_tab = '{'{64'd18993, 64'd189928, 64'd1899281, 64'd18924731, 64'd189247312,
                     64'd1955555556, 64'd19555555556, 64'd176000000000},
                   '{64'd14505, 64'd145055, 64'd1450549, 64'd14505495, 64'd145054945,
                     64'd1466666667, 64'd14666666667, 64'd176000000000}};
      upper              = 12'd3950;
      lower              = 12'd210;
      range_first        = 4'd3;
      range_second       = 4'd3;
      errors             = 0;
      samples_in         = 0;
      readings_checked   = 0;
      ranges_first_seen  = '0;
      ranges_second_seen = '0;
    endfunction

    function void write_threshold(logic [CFG_IDX_BITS-1:0] idx, logic [THR_BITS-1:0] value);
      if (idx == REG_UPPER) begin
        upper = value;
      end else begin
        lower = value;
      end
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction

    function logic [RANGE_BITS-1:0] step_range(logic [RANGE_BITS-1:0] r,
                                               logic [SAMPLE_W-1:0] raw);
      int n;
      n = int'(r);
      if (raw > upper) n++;
      if (raw < lower) n--;
      if (n < 1) n = 1;
      if (n > 8) n = 8;
      return RANGE_BITS'(n);
    endfunction

    // select is filled in by the caller once the next range is known
    function chan_res_t convert_channel(int ch, logic [RANGE_BITS-1:0] r,
                                        logic [SAMPLE_W-1:0] raw);
      chan_res_t       res;
      int              idx;
      longint unsigned ohms;
      idx = (r >= 1) ? int'(r) - 1 : 0;
      if (idx > 7) idx = 7;
      ohms = (64'(raw) * coef_tab[ch][idx]) >> 16;
      if (ohms > RES_SAT) ohms = RES_SAT;
      res.used_range = r;
      res.select     = '0;
      res.voltage    = VOLT_BITS'((64'(raw) * 64'd3300000) >> SAMPLE_W);
      res.resistance = RES_BITS'(ohms);
      return res;
    endfunction

    function logic [TEMP_BITS-1:0] convert_temperature(logic [SAMPLE_W-1:0] raw);
      longint den;
      longint num;
      longint twice;
      longint quo;
      den   = longint'(1721) * 4096;
      num   = longint'(raw) * 330000000 - longint'(70600000) * 4096;
      twice = 2 * (2700 * den - num) + den;
      // round half up: floor division of the doubled numerator
      if (twice >= 0) begin
        quo = twice / (2 * den);
      end else begin
        quo = -((-twice + 2 * den - 1) / (2 * den));
      end
      return TEMP_BITS'(quo);
    endfunction

    function void note_sample(meter_sample_t s);
      meter_reading_t r;
      r.first        = convert_channel(0, range_first, s.first);
      r.second       = convert_channel(1, range_second, s.second);
      r.temperature  = convert_temperature(s.temperature);
      range_first    = step_range(range_first, s.first);
      range_second   = step_range(range_second, s.second);
      r.first.select  = SEL_BITS'(1 << (range_first - 1));
      r.second.select = SEL_BITS'(1 << (range_second - 1));
      expected_readings.push_back(r);
      samples_in++;
    endfunction

    task report(string what, longint unsigned got, longint unsigned want);
      errors++;
      if (errors <= 30) begin
        $display("MISMATCH reading %0d %s: got 0x%0h, want 0x%0h",
                 readings_checked, what, got, want);
      end
    endtask

    task compare_channel(string tag, chan_res_t got, chan_res_t want);
      if (got.used_range !== want.used_range)
        report({"used_range_", tag}, got.used_range, want.used_range);
      if (got.select !== want.select)
        report({"select_", tag}, got.select, want.select);
      if (got.voltage !== want.voltage)
        report({"voltage_", tag}, got.voltage, want.voltage);
      if (got.resistance !== want.resistance)
        report({"resistance_", tag}, got.resistance, want.resistance);
    endtask

    task check_result(logic [159:0] data);
      meter_reading_t got;
      meter_reading_t want;
      got = data[$bits(meter_reading_t)-1:0];
      if (expected_readings.size() == 0) begin
        report("unexpected transaction", data[63:0], 0);
        return;
      end
      want = expected_readings.pop_front();
      compare_channel("first", got.first, want.first);
      compare_channel("second", got.second, want.second);
      if (got.temperature !== want.temperature)
        report("temperature_centi", got.temperature, want.temperature);
      ranges_first_seen[want.first.used_range - 1]   = 1'b1;
      ranges_second_seen[want.second.used_range - 1] = 1'b1;
      readings_checked++;
    endtask
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    s_axis_tvalid_i;
  logic                    s_axis_tready_o;
  logic [IN_W-1:0]         s_axis_tdata_i;
  logic                    m_axis_tvalid_o;
  logic                    m_axis_tready_i;
  logic [159:0]            m_axis_tdata_o;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index_i;
  logic [THR_BITS-1:0]     cfg_data_i;

  meter_scoreboard sb;
  int              quiet_cycles = 0;
  int              threshold_writes = 0;
  int              burst_left = 0;
  logic [15:0]     ready_pattern = 16'hffff;
  int              pattern_age = 0;

  autorange_resistance_meter uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Receiver: rotate a stall pattern, reload it now and then. Bit 0 is forced
  // on at reload so every pattern holds at least one ready bit.
  always @(posedge clk_i) begin
    if (pattern_age == 0) begin
      case ($urandom_range(0, 3))
        0: ready_pattern = 16'hffff;
        1: ready_pattern = 16'($urandom) & 16'($urandom) | 16'h0001;
        default: ready_pattern = 16'($urandom) | 16'($urandom) | 16'h0001;
      endcase
      pattern_age = $urandom_range(16, 96);
    end else begin
      pattern_age--;
    end
    ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
    m_axis_tready_i <= ready_pattern[0];
  end

  // Check results before noting new samples so a stray result never pairs
  // with a sample taken at the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      quiet_cycles++;
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        sb.check_result(m_axis_tdata_o);
        quiet_cycles = 0;
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        sb.note_sample(meter_sample_t'(s_axis_tdata_i[3*SAMPLE_W-1:0]));
        quiet_cycles = 0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        sb.write_threshold(cfg_index_i, cfg_data_i);
        threshold_writes++;
        quiet_cycles = 0;
      end
      if (quiet_cycles >= QUIET_MAX) begin
        $display("timeout: no transaction for %0d cycles, %0d readings outstanding",
                 quiet_cycles, sb.pending());
        $display("autorange_resistance_meter test failed");
        $finish;
      end
    end
  end

  function automatic meter_sample_t mk_sample(int first, int second, int temperature);
    meter_sample_t s;
    s.first       = SAMPLE_W'(first);
    s.second      = SAMPLE_W'(second);
    s.temperature = SAMPLE_W'(temperature);
    return s;
  endfunction

  // bias towards the range-changing regions and the threshold edges
  function automatic logic [SAMPLE_W-1:0] pick_raw();
    case ($urandom_range(0, 9))
      0, 1, 2: return SAMPLE_W'($urandom_range(0, 255));
      3, 4, 5: return SAMPLE_W'($urandom_range(3840, 4095));
      6: begin
        case ($urandom_range(0, 3))
          0: return sb.upper;
          1: return sb.upper + 1'b1;
          2: return sb.lower;
          default: return sb.lower - 1'b1;
        endcase
      end
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic push_sample(input meter_sample_t s);
    int gap;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(IN_W - 3 * SAMPLE_W){1'b0}}, s};
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic push_random(input int count);
    meter_sample_t s;
    repeat (count) begin
      s.first       = pick_raw();
      s.second      = pick_raw();
      s.temperature = SAMPLE_W'($urandom);
      push_sample(s);
    end
  endtask

  // hold the sender until every reading is back and the pipeline is empty;
  // let the sampling edge pass first so the last accepted sample is already noted
  task automatic drain_readings();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 2) @(posedge clk_i);
  endtask

  task automatic set_thresholds(input logic [THR_BITS-1:0] up, input logic [THR_BITS-1:0] lo);
    drain_readings();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_UPPER;
    cfg_data_i  <= up;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= REG_LOWER;
    cfg_data_i  <= lo;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    sb = new();
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= REG_UPPER;
    cfg_data_i      <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset thresholds: field extremes, saturation at both ends, threshold edges
    push_sample(mk_sample(0, 0, 0));
    push_sample(mk_sample(4095, 4095, 4095));
    repeat (7) push_sample(mk_sample(4095, 0, 4095));
    repeat (8) push_sample(mk_sample(0, 4095, 0));
    push_sample(mk_sample(3950, 210, 2048));
    push_sample(mk_sample(3951, 209, 1));
    push_sample(mk_sample(210, 3950, 4094));
    push_sample(mk_sample(209, 3951, 2047));
    push_sample(mk_sample(12'haaa, 12'h555, 12'haaa));
    push_sample(mk_sample(12'h555, 12'haaa, 12'h555));
    push_random(80);
    drain_readings();
    push_random(80);

    // ranges frozen: nothing can exceed 4095 or fall below 0
    set_thresholds(12'd4095, 12'd0);
    push_random(60);

    // both thresholds crossed by every mid-scale sample: steps cancel
    set_thresholds(12'd0, 12'd4095);
    push_sample(mk_sample(2048, 2048, 1000));
    push_sample(mk_sample(0, 4095, 3000));
    push_sample(mk_sample(4095, 0, 500));
    push_sample(mk_sample(1, 4094, 4095));
    push_random(60);

    set_thresholds(12'd2048, 12'd2048);
    push_random(60);

    repeat (3) begin
      set_thresholds(THR_BITS'($urandom), THR_BITS'($urandom));
      push_random(60);
    end

    set_thresholds(12'd3950, 12'd210);
    push_random(80);

    drain_readings();
    repeat (8) @(posedge clk_i);

    $display("run: %0d samples, %0d readings checked, %0d threshold writes, %0d errors",
             sb.samples_in, sb.readings_checked, threshold_writes, sb.errors);
    $display("ranges used: first %b, second %b (bit k = range k+1)",
             sb.ranges_first_seen, sb.ranges_second_seen);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("autorange_resistance_meter test passed");
    end else begin
      $display("autorange_resistance_meter test failed");
    end
    $finish;
  end

endmodule
